/* rtl/twhl_pkg.sv */
// shared types, field widths and codes for the two-wire handshake link
// no dependencies; used by every module under rtl
package twhl_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int IDX_W         = $clog2(BITS_PER_BYTE);
  localparam int TIMER_BITS    = 16;
  localparam int TIMEOUT_W     = 16;
  localparam int GAP_W         = 8;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [GAP_W-1:0]     GAP_RESET     = 8'd0;

  // request kind carried in tuser
  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_SEND = 2'd1;
  localparam logic [1:0] FUNC_RECV = 2'd2;

  // completion status
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_WR_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_RD_TIMEOUT = 2'd2;

  // line drive pairs, bit 0 is line0, 0 pulls low
  localparam logic [1:0] DRV_RELEASED = 2'b11;
  localparam logic [1:0] DRV_LINE0    = 2'b10;
  localparam logic [1:0] DRV_LINE1    = 2'b01;

  // register indexes
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_GAP     = 1'b1;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] tx_byte;
    logic       final_byte;
    logic       line_a_in;
    logic       line_b_in;
  } item_t;

  typedef struct packed {
    logic       drive_line0;
    logic       drive_line1;
    logic       busy_res;
    logic       byte_done;
    logic [7:0] rx_byte;
    logic [1:0] status;
    logic       transfer_done;
  } result_t;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] timeout_ticks;
    logic [GAP_W-1:0]     bit_gap_ticks;
  } cfg_t;

endpackage

/* rtl/twhl_apb.sv */
// configuration registers behind the apb-style port
// depends on twhl_pkg
module twhl_apb (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output twhl_pkg::cfg_t      cfg
);

  logic [twhl_pkg::TIMEOUT_W-1:0] timeout_ticks;
  logic [twhl_pkg::GAP_W-1:0]     bit_gap_ticks;
  logic                           wr_en;

  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= twhl_pkg::TIMEOUT_RESET;
      bit_gap_ticks <= twhl_pkg::GAP_RESET;
    end else if (wr_en) begin
      if (paddr[2] == twhl_pkg::REG_TIMEOUT) begin
        timeout_ticks <= pwdata[twhl_pkg::TIMEOUT_W-1:0];
      end else begin
        bit_gap_ticks <= pwdata[twhl_pkg::GAP_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == twhl_pkg::REG_GAP) begin
      prdata = {{(32-twhl_pkg::GAP_W){1'b0}}, bit_gap_ticks};
    end else begin
      prdata = {{(32-twhl_pkg::TIMEOUT_W){1'b0}}, timeout_ticks};
    end
  end

  assign cfg.timeout_ticks = timeout_ticks;
  assign cfg.bit_gap_ticks = bit_gap_ticks;

endmodule

/* rtl/twhl_core.sv */
// bit handshake sequencer: state registers and next-state logic, one tick per step
// depends on twhl_pkg
module twhl_core #(
  parameter int TIMER_BITS = twhl_pkg::TIMER_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  twhl_pkg::item_t     item,
  input  twhl_pkg::cfg_t      cfg,
  output twhl_pkg::result_t   result
);

  localparam logic [2:0] PH_IDLE        = 3'd0;
  localparam logic [2:0] PH_TX_ASSERT   = 3'd1;
  localparam logic [2:0] PH_TX_RELEASE  = 3'd2;
  localparam logic [2:0] PH_RX_WAIT     = 3'd3;
  localparam logic [2:0] PH_RX_ACK_ONE  = 3'd4;
  localparam logic [2:0] PH_RX_ACK_ZERO = 3'd5;
  localparam logic [2:0] PH_GAP         = 3'd6;

  localparam int IW    = twhl_pkg::IDX_W;
  localparam int GW    = twhl_pkg::GAP_W;
  localparam int CMP_W = (TIMER_BITS > twhl_pkg::TIMEOUT_W) ? TIMER_BITS : twhl_pkg::TIMEOUT_W;
  localparam logic [IW-1:0] LAST_BIT = IW'(twhl_pkg::BITS_PER_BYTE - 1);

  logic [2:0]            phase, phase_next;
  logic [7:0]            shift_reg, shift_reg_next;
  logic [IW-1:0]         bit_index, bit_index_next;
  logic [TIMER_BITS-1:0] wait_timer, wait_timer_next;
  logic [GW-1:0]         gap_counter, gap_counter_next;
  logic                  is_receive, is_receive_next;
  logic                  is_final, is_final_next;
  logic [1:0]            line_drive, line_drive_next;

  logic       expired;
  logic       tx_line;
  logic       ack_line;
  logic       fin_bit;
  logic       adv_bit;
  logic       done;
  logic [1:0] code;
  logic       a, b;

  assign a = item.line_a_in;
  assign b = item.line_b_in;

  // a wait runs out once the timer reaches the limit or saturates
  assign expired = (CMP_W'(wait_timer) >= CMP_W'(cfg.timeout_ticks)) || (&wait_timer);
  assign tx_line  = shift_reg[0] ? a : b;
  assign ack_line = (phase == PH_RX_ACK_ONE) ? b : a;

  always_comb begin
    phase_next       = phase;
    shift_reg_next   = shift_reg;
    bit_index_next   = bit_index;
    wait_timer_next  = wait_timer;
    gap_counter_next = gap_counter;
    is_receive_next  = is_receive;
    is_final_next    = is_final;
    line_drive_next  = line_drive;
    fin_bit          = 1'b0;
    adv_bit          = 1'b0;
    done             = 1'b0;
    code             = twhl_pkg::ST_OK;

    case (phase)
      PH_IDLE: begin
        if (item.func == twhl_pkg::FUNC_SEND || item.func == twhl_pkg::FUNC_RECV) begin
          is_receive_next  = (item.func == twhl_pkg::FUNC_RECV);
          is_final_next    = item.final_byte;
          bit_index_next   = '0;
          gap_counter_next = '0;
          wait_timer_next  = '0;
          if (item.func == twhl_pkg::FUNC_RECV) begin
            shift_reg_next = '0;
            phase_next     = PH_RX_WAIT;
          end else begin
            shift_reg_next  = item.tx_byte;
            line_drive_next = item.tx_byte[0] ? twhl_pkg::DRV_LINE0 : twhl_pkg::DRV_LINE1;
            phase_next      = PH_TX_ASSERT;
          end
        end
      end
      PH_TX_ASSERT: begin
        if (!tx_line) begin
          line_drive_next = twhl_pkg::DRV_RELEASED;
          wait_timer_next = '0;
          phase_next      = PH_TX_RELEASE;
        end else if (expired) begin
          done = 1'b1;
          code = twhl_pkg::ST_WR_TIMEOUT;
        end else begin
          wait_timer_next = wait_timer + 1'b1;
        end
      end
      PH_TX_RELEASE: begin
        if (tx_line) begin
          fin_bit = 1'b1;
        end else if (expired) begin
          done = 1'b1;
          code = twhl_pkg::ST_WR_TIMEOUT;
        end else begin
          wait_timer_next = wait_timer + 1'b1;
        end
      end
      PH_RX_WAIT: begin
        if (!(a && b)) begin
          wait_timer_next = '0;
          if (a && !b) begin
            shift_reg_next  = {1'b1, shift_reg[7:1]};
            line_drive_next = twhl_pkg::DRV_LINE1;
            phase_next      = PH_RX_ACK_ONE;
          end else begin
            shift_reg_next  = {1'b0, shift_reg[7:1]};
            line_drive_next = twhl_pkg::DRV_LINE0;
            phase_next      = PH_RX_ACK_ZERO;
          end
        end else if (expired) begin
          done = 1'b1;
          code = twhl_pkg::ST_RD_TIMEOUT;
        end else begin
          wait_timer_next = wait_timer + 1'b1;
        end
      end
      PH_RX_ACK_ONE, PH_RX_ACK_ZERO: begin
        if (ack_line) begin
          line_drive_next = twhl_pkg::DRV_RELEASED;
          fin_bit         = 1'b1;
        end else if (expired) begin
          done = 1'b1;
          code = twhl_pkg::ST_WR_TIMEOUT;
        end else begin
          wait_timer_next = wait_timer + 1'b1;
        end
      end
      PH_GAP: begin
        if (gap_counter > GW'(1)) begin
          gap_counter_next = gap_counter - 1'b1;
        end else begin
          gap_counter_next = '0;
          adv_bit          = 1'b1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    // end of one bit: shift out a sent bit, then gap, next bit or end of byte
    if (fin_bit) begin
      if (!is_receive) begin
        shift_reg_next = {1'b0, shift_reg[7:1]};
      end
      if (cfg.bit_gap_ticks != '0) begin
        gap_counter_next = cfg.bit_gap_ticks;
        phase_next       = PH_GAP;
      end else begin
        adv_bit = 1'b1;
      end
    end

    if (adv_bit) begin
      if (bit_index >= LAST_BIT) begin
        done = 1'b1;
      end else begin
        bit_index_next  = bit_index + 1'b1;
        wait_timer_next = '0;
        if (is_receive) begin
          phase_next = PH_RX_WAIT;
        end else begin
          line_drive_next = shift_reg_next[0] ? twhl_pkg::DRV_LINE0 : twhl_pkg::DRV_LINE1;
          phase_next      = PH_TX_ASSERT;
        end
      end
    end

    if (done) begin
      phase_next = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      shift_reg   <= '0;
      bit_index   <= '0;
      wait_timer  <= '0;
      gap_counter <= '0;
      is_receive  <= 1'b0;
      is_final    <= 1'b0;
      line_drive  <= twhl_pkg::DRV_RELEASED;
    end else if (step) begin
      phase       <= phase_next;
      shift_reg   <= shift_reg_next;
      bit_index   <= bit_index_next;
      wait_timer  <= wait_timer_next;
      gap_counter <= gap_counter_next;
      is_receive  <= is_receive_next;
      is_final    <= is_final_next;
      line_drive  <= line_drive_next;
    end
  end

  always_comb begin
    result.drive_line0   = line_drive_next[0];
    result.drive_line1   = line_drive_next[1];
    result.busy_res      = (phase_next != PH_IDLE);
    result.byte_done     = done;
    result.rx_byte       = (done && code == twhl_pkg::ST_OK && is_receive_next) ?
                           shift_reg_next : 8'd0;
    result.status        = done ? code : twhl_pkg::ST_OK;
    result.transfer_done = done && is_final_next;
  end

endmodule

/* rtl/twhl_out_reg.sv */
// result register for the master stream side
// depends on twhl_pkg
module twhl_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  twhl_pkg::result_t   result_in,
  input  logic                taken,
  output logic                valid,
  output twhl_pkg::result_t   result_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (taken) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

/* rtl/two_wire_handshake_link.sv */
// top level of the two-wire handshake link: stream ports, apb registers
// depends on twhl_pkg, twhl_apb, twhl_core, twhl_out_reg
//
// usage
//   every request on the slave stream is one sampling tick of the link pins.
//   tuser carries the command (tick only, send a byte, receive a byte),
//   tlast marks the byte as the last of a transfer, and tdata carries the
//   byte to send plus the sampled levels of lines a and b.
//   every request gives exactly one request on the master stream: the line
//   drives, busy, byte done with its status and received byte; tlast there
//   flags the completion of a byte marked last.
//   the result is registered: a request taken at a clock edge shows its result
//   on the master stream in the next cycle. throughput is one request per cycle
//   while the receiver takes results, set by the single state update of the bit
//   sequencer between the slave handshake and the result register.
//   when the receiver stalls, the result register holds its request and the
//   slave side stops taking ticks; nothing is dropped. a new tick is taken
//   in the same cycle the held result is taken.
//   reset clears the sequencer to idle with both lines released, loads the
//   timeout register with 1000 ticks and the bit gap with 0, and empties the
//   result register.
//   registers: timeout_ticks at byte address 0, bit_gap_ticks at 4; write
//   them only while no byte is in progress.
module two_wire_handshake_link #(
  parameter int TIMER_BITS = twhl_pkg::TIMER_BITS
) (
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // tx_byte[7:0], line_a_in[8], line_b_in[9], zero[15:10]
  input  logic [1:0]  s_axis_tuser,  // func[1:0]
  input  logic        s_axis_tlast,  // final_byte
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // drive_line0[0], drive_line1[1], busy_res[2],
                                     // byte_done[3], rx_byte[11:4], status[13:12], zero[15:14]
  output logic        m_axis_tlast,  // transfer_done
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  twhl_pkg::cfg_t    cfg;
  twhl_pkg::item_t   item;
  twhl_pkg::result_t result_next;
  twhl_pkg::result_t result;
  logic              step;

  assign pready = 1'b1;

  twhl_apb u_apb (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // unpack the tick
  assign item.func       = s_axis_tuser;
  assign item.tx_byte    = s_axis_tdata[7:0];
  assign item.final_byte = s_axis_tlast;
  assign item.line_a_in  = s_axis_tdata[8];
  assign item.line_b_in  = s_axis_tdata[9];

  // take a tick whenever the result register is empty or being emptied
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;

  twhl_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .cfg    (cfg),
    .result (result_next)
  );

  twhl_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (step),
    .result_in  (result_next),
    .taken      (m_axis_tready),
    .valid      (m_axis_tvalid),
    .result_out (result)
  );

  // pack the result
  assign m_axis_tdata = {2'b00, result.status, result.rx_byte, result.byte_done,
                         result.busy_res, result.drive_line1, result.drive_line0};
  assign m_axis_tlast = result.transfer_done;

endmodule

/* test/two_wire_handshake_link_tb.sv */
`timescale 1ns / 100ps
// self-checking bench for two_wire_handshake_link: directed rows, then random link traffic
// depends on twhl_pkg and the rtl under rtl/; checks outputs against the model or typed rows
module two_wire_handshake_link_tb;

  // func value with no command behind it, must act as a plain tick
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  // register settings for the random runs, reset values first, timeout extremes included
  localparam int RUN_COUNT = 7;
  localparam int RUN_ITEMS = 200;
  localparam logic [15:0] RUN_TIMEOUT [0:RUN_COUNT-1] =
    '{16'd1000, 16'd0, 16'd65535, 16'd2, 16'd1, 16'd5, 16'd400};
  localparam logic [7:0] RUN_GAP [0:RUN_COUNT-1] =
    '{8'd0, 8'd0, 8'd3, 8'd40, 8'd1, 8'd0, 8'd12};

  // sequencer phases of the local link model
  typedef enum logic [2:0] {
    LP_IDLE, LP_TX_ASSERT, LP_TX_RELEASE, LP_RX_WAIT, LP_RX_ACK_ONE, LP_RX_ACK_ZERO, LP_GAP
  } link_phase_t;

  typedef enum logic [1:0] {ROW_TICK, ROW_CFG, ROW_XFER} row_kind_t;

  // one line of the directed list; want is only used when typed is set
  typedef struct packed {
    row_kind_t           kind;
    twhl_pkg::item_t     it;
    logic                typed;
    twhl_pkg::result_t   want;
    logic                reg_sel;
    logic [15:0]         reg_val;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = twhl_pkg::FUNC_TICK;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  two_wire_handshake_link uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk = ~clk;

  // hard stop well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // local link model: own copy of the registers and the bit sequencer state
  // ---------------------------------------------------------------------------
  logic [twhl_pkg::TIMEOUT_W-1:0]  cfg_timeout = twhl_pkg::TIMEOUT_RESET;
  logic [twhl_pkg::GAP_W-1:0]      cfg_gap     = twhl_pkg::GAP_RESET;
  link_phase_t                     ph          = LP_IDLE;
  logic [7:0]                      shreg       = '0;
  logic [twhl_pkg::IDX_W-1:0]      bidx        = '0;
  logic [twhl_pkg::TIMER_BITS-1:0] wtimer      = '0;
  logic [twhl_pkg::GAP_W-1:0]      gcount      = '0;
  logic                            rx_mode     = 1'b0;
  logic                            fin_mark    = 1'b0;
  logic [1:0]                      drv         = twhl_pkg::DRV_RELEASED;

  twhl_pkg::result_t outputs_due [$];  // model outputs still waiting for their request
  int      mismatches = 0;
  int      burst_left = 0;
  logic [7:0] peer_byte = '0;  // byte the far end sends during a receive

  // load the wait for the next bit; a send bit pulls its line right away
  function automatic void start_bit();
    wtimer = '0;
    if (rx_mode) begin
      ph = LP_RX_WAIT;
    end else begin
      drv = shreg[0] ? twhl_pkg::DRV_LINE0 : twhl_pkg::DRV_LINE1;
      ph  = LP_TX_ASSERT;
    end
  endfunction

  // 1 when the byte is complete
  function automatic logic advance_bit();
    if (bidx == twhl_pkg::IDX_W'(twhl_pkg::BITS_PER_BYTE - 1)) begin
      ph = LP_IDLE;
      return 1'b1;
    end
    bidx = bidx + 1'b1;
    start_bit();
    return 1'b0;
  endfunction

  function automatic logic close_bit();
    if (!rx_mode) shreg = shreg >> 1;
    if (cfg_gap != '0) begin
      gcount = cfg_gap;
      ph     = LP_GAP;
      return 1'b0;
    end
    return advance_bit();
  endfunction

  // unmet wait: abort once the timer has reached the limit or saturated, else count up
  function automatic logic timed_out();
    if (wtimer >= cfg_timeout || wtimer == '1) return 1'b1;
    wtimer = wtimer + 1'b1;
    return 1'b0;
  endfunction

  // one tick of the link: updates the model state, returns the output request
  function automatic twhl_pkg::result_t next_link_outputs(input twhl_pkg::item_t it);
    twhl_pkg::result_t r;
    logic              done;
    logic [1:0]        code;
    logic              ln;
    done = 1'b0;
    code = twhl_pkg::ST_OK;
    case (ph)
      LP_IDLE: begin
        if (it.func == twhl_pkg::FUNC_SEND || it.func == twhl_pkg::FUNC_RECV) begin
          rx_mode  = (it.func == twhl_pkg::FUNC_RECV);
          fin_mark = it.final_byte;
          shreg    = rx_mode ? 8'h00 : it.tx_byte;
          bidx     = '0;
          gcount   = '0;
          start_bit();
        end
      end
      LP_TX_ASSERT: begin
        ln = shreg[0] ? it.line_a_in : it.line_b_in;
        if (!ln) begin
          drv    = twhl_pkg::DRV_RELEASED;
          wtimer = '0;
          ph     = LP_TX_RELEASE;
        end else if (timed_out()) begin
          done = 1'b1;
          code = twhl_pkg::ST_WR_TIMEOUT;
        end
      end
      LP_TX_RELEASE: begin
        ln = shreg[0] ? it.line_a_in : it.line_b_in;
        if (ln) begin
          done = close_bit();
        end else if (timed_out()) begin
          done = 1'b1;
          code = twhl_pkg::ST_WR_TIMEOUT;
        end
      end
      LP_RX_WAIT: begin
        if (!(it.line_a_in && it.line_b_in)) begin
          wtimer = '0;
          // b low alone is a one, anything else a zero
          if (it.line_a_in && !it.line_b_in) begin
            shreg = {1'b1, shreg[7:1]};
            drv   = twhl_pkg::DRV_LINE1;
            ph    = LP_RX_ACK_ONE;
          end else begin
            shreg = {1'b0, shreg[7:1]};
            drv   = twhl_pkg::DRV_LINE0;
            ph    = LP_RX_ACK_ZERO;
          end
        end else if (timed_out()) begin
          done = 1'b1;
          code = twhl_pkg::ST_RD_TIMEOUT;
        end
      end
      LP_RX_ACK_ONE, LP_RX_ACK_ZERO: begin
        ln = (ph == LP_RX_ACK_ONE) ? it.line_b_in : it.line_a_in;
        if (ln) begin
          drv  = twhl_pkg::DRV_RELEASED;
          done = close_bit();
        end else if (timed_out()) begin
          done = 1'b1;
          code = twhl_pkg::ST_WR_TIMEOUT;
        end
      end
      LP_GAP: begin
        if (gcount > 1) begin
          gcount = gcount - 1'b1;
        end else begin
          gcount = '0;
          done   = advance_bit();
        end
      end
      default: ph = LP_IDLE;
    endcase
    // an abort leaves the drives where they were
    if (done) ph = LP_IDLE;
    r.drive_line0   = drv[0];
    r.drive_line1   = drv[1];
    r.busy_res      = (ph != LP_IDLE);
    r.byte_done     = done;
    r.rx_byte       = (done && code == twhl_pkg::ST_OK && rx_mode) ? shreg : 8'h00;
    r.status        = done ? code : twhl_pkg::ST_OK;
    r.transfer_done = done && fin_mark;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // far end of the link: answers the model's current wait, {a, b}
  // hold keeps the lines as they were, so the wait stays unmet one more tick
  // ---------------------------------------------------------------------------
  function automatic logic [1:0] peer_lines(input logic hold);
    logic [1:0] bit_lines;
    // a zero may come as a low or as both low
    bit_lines = peer_byte[bidx] ? 2'b10 : ($urandom_range(0, 1) ? 2'b00 : 2'b01);
    case (ph)
      LP_TX_ASSERT:   return hold ? 2'b11 : (shreg[0] ? 2'b01 : 2'b10);
      LP_TX_RELEASE:  return hold ? (shreg[0] ? 2'b01 : 2'b10) : 2'b11;
      LP_RX_WAIT:     return hold ? 2'b11 : bit_lines;
      LP_RX_ACK_ONE:  return hold ? 2'b10 : 2'b11;
      LP_RX_ACK_ZERO: return hold ? 2'b01 : 2'b11;
      default:        return 2'b11;
    endcase
  endfunction

  function automatic string fmt_outputs(input twhl_pkg::result_t r);
    return $sformatf("drv0 %b drv1 %b busy %b done %b rx %h status %0d last %b",
                     r.drive_line0, r.drive_line1, r.busy_res, r.byte_done, r.rx_byte,
                     r.status, r.transfer_done);
  endfunction

  function automatic twhl_pkg::result_t link_out(input logic d0, input logic d1,
                                                 input logic busy, input logic done,
                                                 input logic [7:0] rx,
                                                 input logic [1:0] st, input logic last);
    twhl_pkg::result_t r;
    r.drive_line0   = d0;
    r.drive_line1   = d1;
    r.busy_res      = busy;
    r.byte_done     = done;
    r.rx_byte       = rx;
    r.status        = st;
    r.transfer_done = last;
    return r;
  endfunction

  function automatic row_t tick_row(input logic [1:0] f, input logic [7:0] txb, input logic fin,
                                    input logic a, input logic b, input logic typed,
                                    input twhl_pkg::result_t want);
    row_t r;
    r         = '0;
    r.kind    = ROW_TICK;
    r.it      = '{func: f, tx_byte: txb, final_byte: fin, line_a_in: a, line_b_in: b};
    r.typed   = typed;
    r.want    = want;
    return r;
  endfunction

  function automatic row_t cfg_row(input logic sel, input logic [15:0] val);
    row_t r;
    r         = '0;
    r.kind    = ROW_CFG;
    r.reg_sel = sel;
    r.reg_val = val;
    return r;
  endfunction

  // whole byte against a prompt far end; for a receive tx_byte is what the far end sends
  function automatic row_t xfer_row(input logic [1:0] f, input logic [7:0] data, input logic fin);
    row_t r;
    r      = tick_row(f, data, fin, 1'b1, 1'b1, 1'b0, '0);
    r.kind = ROW_XFER;
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // slave stream driver: bursts of requests with random gaps between them
  // inputs change at the falling edge, the handshake is seen at the rising edge
  // ---------------------------------------------------------------------------
  task automatic send_tick(input twhl_pkg::item_t it, input logic typed,
                           input twhl_pkg::result_t want);
    twhl_pkg::result_t predicted;
    @(negedge clk);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, it.line_b_in, it.line_a_in, it.tx_byte};
    s_axis_tuser  <= it.func;
    s_axis_tlast  <= it.final_byte;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    burst_left--;
    // model runs here, so the next request is built from the updated state
    predicted = next_link_outputs(it);
    outputs_due.push_back(typed ? want : predicted);
  endtask

  // idle: start a byte most of the time; busy: far end answers, with holds and noise
  task automatic random_tick(input int stall_pct, input int noise_pct);
    twhl_pkg::item_t it;
    it.tx_byte    = 8'($urandom);
    it.final_byte = 1'($urandom);
    it.func       = 2'($urandom);  // ignored while busy
    {it.line_a_in, it.line_b_in} = 2'($urandom);
    if (ph == LP_IDLE) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: it.func = twhl_pkg::FUNC_SEND;
        4, 5, 6, 7: it.func = twhl_pkg::FUNC_RECV;
        8:          it.func = twhl_pkg::FUNC_TICK;
        default:    it.func = FUNC_SPARE;
      endcase
      peer_byte = 8'($urandom);
    end else if ($urandom_range(0, 99) >= noise_pct) begin
      {it.line_a_in, it.line_b_in} = peer_lines($urandom_range(0, 99) < stall_pct);
    end
    send_tick(it, 1'b0, '0);
  endtask

  // far end answers every wait at once until the byte is over
  task automatic finish_byte();
    while (ph != LP_IDLE) random_tick(0, 0);
  endtask

  // stop the stream and let every outstanding request come back
  task automatic settle();
    finish_byte();
    @(negedge clk) s_axis_tvalid <= 1'b0;
    while (outputs_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // apb transfer: setup cycle, then access cycle until pready
  task automatic reg_access(input logic wr, input logic idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // write a register, mirror it in the model, read it back
  task automatic set_reg(input logic idx, input logic [15:0] val);
    logic [31:0] rd;
    logic [31:0] want_rd;
    reg_access(1'b1, idx, {16'b0, val}, rd);
    if (idx == twhl_pkg::REG_TIMEOUT) begin
      cfg_timeout = val;
      want_rd     = {16'b0, val};
    end else begin
      cfg_gap = val[7:0];
      want_rd = {24'b0, val[7:0]};
    end
    reg_access(1'b0, idx, 32'b0, rd);
    if (rd !== want_rd)
      note_mismatch($sformatf("register %0d read back: expected %h, actual %h",
                              idx, want_rd, rd));
  endtask

  // ---------------------------------------------------------------------------
  // master stream: receiver stall pattern and the output check
  // ---------------------------------------------------------------------------
  int rdy_mode  = 0;
  int rdy_left  = 0;
  int rdy_count = 0;

  // segments of random length: always ready, ready two of three, coin flip, long stalls
  always @(negedge clk) begin
    if (rdy_left == 0) begin
      rdy_mode = $urandom_range(0, 3);
      rdy_left = $urandom_range(1, 60);
    end
    rdy_left--;
    rdy_count++;
    case (rdy_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= (rdy_count % 3) != 0;
      2:       m_axis_tready <= 1'($urandom);
      default: m_axis_tready <= (rdy_count % 8) < 2;
    endcase
  end

  // every accepted output request is matched against the oldest model output
  always @(posedge clk) begin : watch_outputs
    twhl_pkg::result_t seen;
    twhl_pkg::result_t due;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen.drive_line0   = m_axis_tdata[0];
      seen.drive_line1   = m_axis_tdata[1];
      seen.busy_res      = m_axis_tdata[2];
      seen.byte_done     = m_axis_tdata[3];
      seen.rx_byte       = m_axis_tdata[11:4];
      seen.status        = m_axis_tdata[13:12];
      seen.transfer_done = m_axis_tlast;
      if (outputs_due.size() == 0) begin
        note_mismatch({"output request with nothing due: ", fmt_outputs(seen)});
      end else begin
        due = outputs_due.pop_front();
        if (seen !== due)
          note_mismatch({"expected ", fmt_outputs(due), " | actual ", fmt_outputs(seen)});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  row_t dir_rows [$];

  initial begin
    // after reset: released, idle, timeout 1000, no gap
    dir_rows.push_back(tick_row(twhl_pkg::FUNC_TICK, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1,
                                link_out(1'b1, 1'b1, 1'b0, 1'b0, 8'h00,
                                         twhl_pkg::ST_OK, 1'b0)));
    // unknown func is just a tick
    dir_rows.push_back(tick_row(FUNC_SPARE, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b1,
                                link_out(1'b1, 1'b1, 1'b0, 1'b0, 8'h00,
                                         twhl_pkg::ST_OK, 1'b0)));
    // zero timeout: every unmet wait aborts on its first tick
    dir_rows.push_back(cfg_row(twhl_pkg::REG_TIMEOUT, 16'd0));
    // send starting with a zero pulls line1
    dir_rows.push_back(tick_row(twhl_pkg::FUNC_SEND, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1,
                                link_out(1'b1, 1'b0, 1'b1, 1'b0, 8'h00,
                                         twhl_pkg::ST_OK, 1'b0)));
    // b never drops: write timeout, drive kept, receive command ignored
    dir_rows.push_back(tick_row(twhl_pkg::FUNC_RECV, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b1,
                                link_out(1'b1, 1'b0, 1'b0, 1'b1, 8'h00,
                                         twhl_pkg::ST_WR_TIMEOUT, 1'b1)));
    // send starting with a one pulls line0
    dir_rows.push_back(tick_row(twhl_pkg::FUNC_SEND, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b1,
                                link_out(1'b0, 1'b1, 1'b1, 1'b0, 8'h00,
                                         twhl_pkg::ST_OK, 1'b0)));
    dir_rows.push_back(tick_row(twhl_pkg::FUNC_TICK, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, '0));
    // a stays low after the release: write timeout with both lines released
    dir_rows.push_back(tick_row(twhl_pkg::FUNC_TICK, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1,
                                link_out(1'b1, 1'b1, 1'b0, 1'b1, 8'h00,
                                         twhl_pkg::ST_WR_TIMEOUT, 1'b0)));
    // receive start leaves the drives alone; no bit start gives a read timeout
    dir_rows.push_back(tick_row(twhl_pkg::FUNC_RECV, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1,
                                link_out(1'b1, 1'b1, 1'b1, 1'b0, 8'h00,
                                         twhl_pkg::ST_OK, 1'b0)));
    dir_rows.push_back(tick_row(twhl_pkg::FUNC_TICK, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1,
                                link_out(1'b1, 1'b1, 1'b0, 1'b1, 8'h00,
                                         twhl_pkg::ST_RD_TIMEOUT, 1'b1)));
    // both lines low is a zero; a held low during the ack is a write timeout
    dir_rows.push_back(tick_row(twhl_pkg::FUNC_RECV, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, '0));
    dir_rows.push_back(tick_row(twhl_pkg::FUNC_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, '0));
    dir_rows.push_back(tick_row(twhl_pkg::FUNC_TICK, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1,
                                link_out(1'b0, 1'b1, 1'b0, 1'b1, 8'h00,
                                         twhl_pkg::ST_WR_TIMEOUT, 1'b0)));
    // a full byte with only the top bit set
    dir_rows.push_back(xfer_row(twhl_pkg::FUNC_RECV, 8'h80, 1'b1));

    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_TICK: send_tick(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
        ROW_CFG: begin
          settle();
          set_reg(dir_rows[i].reg_sel, dir_rows[i].reg_val);
        end
        default: begin
          peer_byte = dir_rows[i].it.tx_byte;
          send_tick(dir_rows[i].it, 1'b0, '0);
          finish_byte();
        end
      endcase
    end

    // random traffic under each register setting; registers change only when idle
    for (int run = 0; run < RUN_COUNT; run++) begin
      settle();
      set_reg(twhl_pkg::REG_TIMEOUT, RUN_TIMEOUT[run]);
      set_reg(twhl_pkg::REG_GAP, {8'b0, RUN_GAP[run]});
      repeat (RUN_ITEMS) random_tick(35, 4);
    end

    settle();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/twhl_pkg.sv
rtl/twhl_apb.sv
rtl/twhl_core.sv
rtl/twhl_out_reg.sv
rtl/two_wire_handshake_link.sv
test/two_wire_handshake_link_tb.sv
